// ----- rtl/tksd_pkg.sv -----
// Shared types, constants and tables for the terminal key sequence decoder.
// Holds the event codes, the byte classes, the escape key table and the
// single-byte decoder. Depends on nothing.
package tksd_pkg;

  // Event kinds on the result channel
  localparam logic [3:0] EV_CHAR   = 4'd0;
  localparam logic [3:0] EV_EOF    = 4'd1;
  localparam logic [3:0] EV_ESC    = 4'd2;
  localparam logic [3:0] EV_ENTER  = 4'd3;
  localparam logic [3:0] EV_UP     = 4'd4;
  localparam logic [3:0] EV_DOWN   = 4'd5;
  localparam logic [3:0] EV_RIGHT  = 4'd6;
  localparam logic [3:0] EV_LEFT   = 4'd7;
  localparam logic [3:0] EV_HOME   = 4'd8;
  localparam logic [3:0] EV_END    = 4'd9;
  localparam logic [3:0] EV_INS    = 4'd10;
  localparam logic [3:0] EV_DEL    = 4'd11;
  localparam logic [3:0] EV_PGUP   = 4'd12;
  localparam logic [3:0] EV_PGDOWN = 4'd13;

  // Configuration register indexes
  localparam logic REG_ESC_IS_COMMAND    = 1'b0;
  localparam logic REG_INVALID_CODEPOINT = 1'b1;

  localparam logic [20:0] INVALID_CP_RESET = 21'd65533;

  // Byte classes
  localparam logic [7:0] BYTE_ESC   = 8'h1B;
  localparam logic [7:0] BYTE_HIGH  = 8'h80;
  localparam logic [7:0] BYTE_CR    = 8'd13;
  localparam logic [7:0] BYTE_DEL   = 8'd127;
  localparam logic [7:0] BYTE_SPACE = 8'd32;

  // Key table geometry
  localparam int KEY_COUNT  = 29;
  localparam int KEY_MAXLEN = 5;
  localparam int KEY_IW     = $clog2(KEY_COUNT);

  typedef struct packed {
    logic [3:0]  kind;
    logic [20:0] cp;
    logic        ctrl;
  } ev_t;

  typedef struct packed {
    logic [2:0]              len;
    logic [KEY_MAXLEN*8-1:0] seq;   // byte 0 in the top bits
    logic [3:0]              kind;
    logic                    ctrl;
  } key_t;

  typedef struct packed {
    logic        has_ev;
    ev_t         ev;
    logic        start_esc;
    logic        start_u8;
    logic [1:0]  u8_rem;
    logic [20:0] u8_acc;
  } dec_t;

  function automatic ev_t mk_ev(input logic [3:0] kind, input logic [20:0] cp,
                                input logic ctrl);
    ev_t e;
    e.kind = kind;
    e.cp   = cp;
    e.ctrl = ctrl;
    return e;
  endfunction

  function automatic key_t mk_key(input logic [2:0] len, input logic [39:0] seq,
                                  input logic [3:0] kind, input logic ctrl);
    key_t k;
    k.len  = len;
    k.seq  = seq;
    k.kind = kind;
    k.ctrl = ctrl;
    return k;
  endfunction

  // Escape key table: bytes that follow ESC
  function automatic key_t key_entry(input logic [KEY_IW-1:0] idx);
    key_t k;
    case (idx)
      5'd0:  k = mk_key(3'd2, 40'h5B41_000000, EV_UP,     1'b0);
      5'd1:  k = mk_key(3'd2, 40'h5B42_000000, EV_DOWN,   1'b0);
      5'd2:  k = mk_key(3'd2, 40'h5B43_000000, EV_RIGHT,  1'b0);
      5'd3:  k = mk_key(3'd2, 40'h5B44_000000, EV_LEFT,   1'b0);
      5'd4:  k = mk_key(3'd2, 40'h5B46_000000, EV_END,    1'b0);
      5'd5:  k = mk_key(3'd2, 40'h5B48_000000, EV_HOME,   1'b0);
      5'd6:  k = mk_key(3'd3, 40'h5B4F46_0000, EV_END,    1'b0);
      5'd7:  k = mk_key(3'd3, 40'h5B4F48_0000, EV_HOME,   1'b0);
      5'd8:  k = mk_key(3'd3, 40'h5B317E_0000, EV_HOME,   1'b0);
      5'd9:  k = mk_key(3'd3, 40'h5B327E_0000, EV_INS,    1'b0);
      5'd10: k = mk_key(3'd3, 40'h5B337E_0000, EV_DEL,    1'b0);
      5'd11: k = mk_key(3'd3, 40'h5B347E_0000, EV_END,    1'b0);
      5'd12: k = mk_key(3'd3, 40'h5B357E_0000, EV_PGUP,   1'b0);
      5'd13: k = mk_key(3'd3, 40'h5B367E_0000, EV_PGDOWN, 1'b0);
      5'd14: k = mk_key(3'd3, 40'h5B377E_0000, EV_HOME,   1'b0);
      5'd15: k = mk_key(3'd3, 40'h5B387E_0000, EV_END,    1'b0);
      5'd16: k = mk_key(3'd5, 40'h5B313B3541, EV_UP,     1'b1);
      5'd17: k = mk_key(3'd5, 40'h5B313B3542, EV_DOWN,   1'b1);
      5'd18: k = mk_key(3'd5, 40'h5B313B3543, EV_RIGHT,  1'b1);
      5'd19: k = mk_key(3'd5, 40'h5B313B3544, EV_LEFT,   1'b1);
      5'd20: k = mk_key(3'd5, 40'h5B333B357E, EV_DEL,    1'b1);
      5'd21: k = mk_key(3'd2, 40'h4F41_000000, EV_UP,     1'b0);
      5'd22: k = mk_key(3'd2, 40'h4F42_000000, EV_DOWN,   1'b0);
      5'd23: k = mk_key(3'd2, 40'h4F43_000000, EV_RIGHT,  1'b0);
      5'd24: k = mk_key(3'd2, 40'h4F44_000000, EV_LEFT,   1'b0);
      5'd25: k = mk_key(3'd2, 40'h4F46_000000, EV_END,    1'b0);
      5'd26: k = mk_key(3'd2, 40'h4F48_000000, EV_HOME,   1'b0);
      5'd27: k = mk_key(3'd3, 40'h5B3543_0000, EV_RIGHT,  1'b1);
      5'd28: k = mk_key(3'd3, 40'h5B3544_0000, EV_LEFT,   1'b1);
      default: k = mk_key(3'd0, 40'h0, EV_CHAR, 1'b0);  // zero length never matches
    endcase
    return k;
  endfunction

  // Decode one byte seen with no escape and no UTF-8 character in progress
  function automatic dec_t fresh_decode(input logic [7:0] b, input logic esc_cmd,
                                        input logic [20:0] inv_cp);
    dec_t d;
    d.has_ev    = 1'b0;
    d.ev        = mk_ev(EV_CHAR, 21'd0, 1'b0);
    d.start_esc = 1'b0;
    d.start_u8  = 1'b0;
    d.u8_rem    = 2'd0;
    d.u8_acc    = 21'd0;
    if (b == BYTE_ESC) begin
      if (esc_cmd) begin
        d.has_ev = 1'b1;
        d.ev     = mk_ev(EV_ESC, 21'd0, 1'b0);
      end else begin
        d.start_esc = 1'b1;
      end
    end else if (b >= BYTE_HIGH) begin
      if (b inside {[8'hC2:8'hDF]}) begin
        d.start_u8 = 1'b1;
        d.u8_rem   = 2'd1;
        d.u8_acc   = {16'd0, b[4:0]};
      end else if (b inside {[8'hE0:8'hEF]}) begin
        d.start_u8 = 1'b1;
        d.u8_rem   = 2'd2;
        d.u8_acc   = {17'd0, b[3:0]};
      end else if (b inside {[8'hF0:8'hF4]}) begin
        d.start_u8 = 1'b1;
        d.u8_rem   = 2'd3;
        d.u8_acc   = {18'd0, b[2:0]};
      end else begin
        d.has_ev = 1'b1;
        d.ev     = mk_ev(EV_CHAR, inv_cp, 1'b0);
      end
    end else if (b == BYTE_CR) begin
      d.has_ev = 1'b1;
      d.ev     = mk_ev(EV_ENTER, 21'd0, 1'b0);
    end else if (b < BYTE_SPACE || b == BYTE_DEL) begin
      d.has_ev = 1'b1;
      d.ev     = mk_ev(EV_CHAR, {13'd0, b}, 1'b1);
    end else begin
      d.has_ev = 1'b1;
      d.ev     = mk_ev(EV_CHAR, {13'd0, b}, 1'b0);
    end
    return d;
  endfunction

endpackage

// ----- rtl/terminal_key_sequence_decoder.sv -----
// Terminal key sequence decoder: top level, sequencer and output register.
// Depends on tksd_pkg for event codes, the key table and the byte decoder.
//
// Takes one terminal byte (or an end-of-stream mark) per item and produces zero
// to six key events, one per cycle unless stalled, through a registered output
// with valid/stall. The input is stalled while an item is in work. An item
// passes through capture and decode when the byte completes a key or a UTF-8
// character, or only extends an open sequence or character. It passes through
// capture, decode and finish when the byte is decoded on its own or an end mark
// closes nothing open. When a failed escape sequence or a malformed UTF-8
// character emits a leading ESC or invalid code point and then replays n
// buffered prefix bytes (n is at most 4), head and replay come before finish.
// The output side can stall any step that emits. The single byte decoder is
// shared: the sequencer steps it through the replayed bytes and the final byte
// one per cycle unless the output stalls. Escape matching compares the buffered
// prefix and the new byte against the constant key table combinationally. The
// event flagged last_of_run is the final event of its item. Write configuration
// only while idle; esc_is_command is sampled when an ESC byte is decoded.
module terminal_key_sequence_decoder #(
  parameter int MAX_SEQUENCE_BYTES = 5
) (
  input  logic        clk,
  input  logic        rst_n,
  // byte input
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_data_byte,
  input  logic        in_end_of_stream,
  // key events
  output logic        out_valid,
  input  logic        out_stall,
  output logic [3:0]  out_event_kind,
  output logic [20:0] out_code_point,
  output logic        out_ctrl_modifier,
  output logic        out_last_of_run,
  // configuration
  input  logic        cfg_wr_en,
  input  logic        cfg_index,
  input  logic [20:0] cfg_wdata
);

  localparam int CW = $clog2(MAX_SEQUENCE_BYTES + 1);  // prefix count
  localparam int IW = $clog2(MAX_SEQUENCE_BYTES);      // prefix buffer index

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECODE,
    ST_HEAD,
    ST_REPLAY,
    ST_TAIL
  } state_t;

  state_t                state_r, state_nxt;
  logic [7:0]            byte_r, byte_nxt;
  logic                  eos_r, eos_nxt;
  logic                  esc_active_r, esc_active_nxt;
  logic [7:0]            esc_bytes_r [MAX_SEQUENCE_BYTES];
  logic [CW-1:0]         esc_count_r, esc_count_nxt;
  logic [1:0]            u8_rem_r, u8_rem_nxt;
  logic [20:0]           u8_acc_r, u8_acc_nxt;
  logic [7:0]            u8_lead_r, u8_lead_nxt;
  tksd_pkg::ev_t         head_r, head_nxt;
  logic [CW-1:0]         rep_n_r, rep_n_nxt;
  logic [IW-1:0]         rep_idx_r, rep_idx_nxt;
  logic                  tail_ev_r, tail_ev_nxt;
  logic                  out_valid_r, out_valid_nxt;
  tksd_pkg::ev_t         out_ev_r, out_ev_nxt;
  logic                  out_last_r, out_last_nxt;
  logic                  esc_cmd_r;
  logic [20:0]           inv_cp_r;

  logic                  buf_we;
  logic                  out_free;
  logic [7:0]            sel_byte;
  tksd_pkg::dec_t        dec;

  // match results
  logic                  m_full, m_part;
  logic [3:0]            m_kind;
  logic                  m_ctrl;

  // UTF-8 continuation check
  logic                  u8_first;
  logic [7:0]            u8_lo, u8_hi;
  logic [20:0]           u8_acc_new;

  assign in_stall          = (state_r != ST_IDLE);
  assign out_valid         = out_valid_r;
  assign out_event_kind    = out_ev_r.kind;
  assign out_code_point    = out_ev_r.cp;
  assign out_ctrl_modifier = out_ev_r.ctrl;
  assign out_last_of_run   = out_last_r;

  assign out_free = !out_valid_r || !out_stall;

  // Shared byte decoder: replayed prefix bytes during replay, else the held byte
  assign sel_byte = (state_r == ST_REPLAY) ? esc_bytes_r[rep_idx_r] : byte_r;
  assign dec      = tksd_pkg::fresh_decode(sel_byte, esc_cmd_r, inv_cp_r);

  // Match the buffered prefix plus the held byte against the key table.
  // Walk the table top down so the lowest full match wins.
  always_comb begin
    tksd_pkg::key_t     e;
    logic               same;
    logic [CW:0]        n1;
    logic [CW:0]        klen;
    logic [7:0]         tb;
    m_full = 1'b0;
    m_part = 1'b0;
    m_kind = tksd_pkg::EV_CHAR;
    m_ctrl = 1'b0;
    n1     = {1'b0, esc_count_r} + (CW+1)'(1);
    for (int i = tksd_pkg::KEY_COUNT - 1; i >= 0; i--) begin
      e    = tksd_pkg::key_entry(tksd_pkg::KEY_IW'(i));
      klen = (CW+1)'(e.len);
      same = 1'b1;
      for (int k = 0; k < tksd_pkg::KEY_MAXLEN; k++) begin
        tb = ((CW+1)'(k) < {1'b0, esc_count_r}) ? esc_bytes_r[IW'(k)] : byte_r;
        if ((CW+1)'(k) < n1 &&
            e.seq[(tksd_pkg::KEY_MAXLEN-1-k)*8 +: 8] != tb) begin
          same = 1'b0;
        end
      end
      if (same && klen >= n1) begin
        if (klen == n1) begin
          m_full = 1'b1;
          m_kind = e.kind;
          m_ctrl = e.ctrl;
        end else begin
          m_part = 1'b1;
        end
      end
    end
  end

  // Strict range of a continuation byte; tighter on the byte after some leads
  always_comb begin
    u8_first = (u8_lead_r >= 8'hF0 && u8_rem_r == 2'd3) ||
               (u8_lead_r >= 8'hE0 && u8_lead_r < 8'hF0 && u8_rem_r == 2'd2) ||
               (u8_lead_r < 8'hE0 && u8_rem_r == 2'd1);
    u8_lo = 8'h80;
    u8_hi = 8'hBF;
    if (u8_first) begin
      case (u8_lead_r)
        8'hE0:   u8_lo = 8'hA0;
        8'hED:   u8_hi = 8'h9F;
        8'hF0:   u8_lo = 8'h90;
        8'hF4:   u8_hi = 8'h8F;
        default: ;
      endcase
    end
    u8_acc_new = {u8_acc_r[14:0], byte_r[5:0]};
  end

  // Sequencer
  always_comb begin
    state_nxt      = state_r;
    byte_nxt       = byte_r;
    eos_nxt        = eos_r;
    esc_active_nxt = esc_active_r;
    esc_count_nxt  = esc_count_r;
    u8_rem_nxt     = u8_rem_r;
    u8_acc_nxt     = u8_acc_r;
    u8_lead_nxt    = u8_lead_r;
    head_nxt       = head_r;
    rep_n_nxt      = rep_n_r;
    rep_idx_nxt    = rep_idx_r;
    tail_ev_nxt    = tail_ev_r;
    buf_we         = 1'b0;
    // drop the output item once taken
    out_valid_nxt  = out_valid_r && out_stall;
    out_ev_nxt     = out_ev_r;
    out_last_nxt   = out_last_r;

    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          byte_nxt  = in_data_byte;
          eos_nxt   = in_end_of_stream;
          state_nxt = ST_DECODE;
        end
      end

      ST_DECODE: begin
        tail_ev_nxt = eos_r || dec.has_ev;
        if (eos_r) begin
          if (esc_active_r) begin
            // flush the sequence: ESC, replay prefix, then EOF
            head_nxt       = tksd_pkg::mk_ev(tksd_pkg::EV_ESC, 21'd0, 1'b0);
            rep_n_nxt      = esc_count_r;
            esc_active_nxt = 1'b0;
            esc_count_nxt  = '0;
            state_nxt      = ST_HEAD;
          end else if (u8_rem_r != 2'd0) begin
            head_nxt    = tksd_pkg::mk_ev(tksd_pkg::EV_CHAR, inv_cp_r, 1'b0);
            rep_n_nxt   = '0;
            u8_rem_nxt  = 2'd0;
            u8_acc_nxt  = 21'd0;
            u8_lead_nxt = 8'd0;
            state_nxt   = ST_HEAD;
          end else begin
            state_nxt = ST_TAIL;
          end
        end else if (esc_active_r) begin
          if (byte_r >= tksd_pkg::BYTE_HIGH ||
              esc_count_r >= CW'(MAX_SEQUENCE_BYTES) ||
              (!m_full && !m_part)) begin
            // failed match: ESC, replay prefix, then the byte afresh
            head_nxt       = tksd_pkg::mk_ev(tksd_pkg::EV_ESC, 21'd0, 1'b0);
            rep_n_nxt      = esc_count_r;
            esc_active_nxt = 1'b0;
            esc_count_nxt  = '0;
            state_nxt      = ST_HEAD;
          end else if (m_full) begin
            if (out_free) begin
              out_valid_nxt  = 1'b1;
              out_ev_nxt     = tksd_pkg::mk_ev(m_kind, 21'd0, m_ctrl);
              out_last_nxt   = 1'b1;
              esc_active_nxt = 1'b0;
              esc_count_nxt  = '0;
              state_nxt      = ST_IDLE;
            end
          end else begin
            // still a prefix: buffer the byte
            buf_we        = 1'b1;
            esc_count_nxt = esc_count_r + CW'(1);
            state_nxt     = ST_IDLE;
          end
        end else if (u8_rem_r != 2'd0) begin
          if (byte_r >= u8_lo && byte_r <= u8_hi) begin
            if (u8_rem_r == 2'd1) begin
              if (out_free) begin
                out_valid_nxt = 1'b1;
                out_ev_nxt    = tksd_pkg::mk_ev(tksd_pkg::EV_CHAR, u8_acc_new, 1'b0);
                out_last_nxt  = 1'b1;
                u8_rem_nxt    = 2'd0;
                u8_acc_nxt    = 21'd0;
                u8_lead_nxt   = 8'd0;
                state_nxt     = ST_IDLE;
              end
            end else begin
              u8_acc_nxt = u8_acc_new;
              u8_rem_nxt = u8_rem_r - 2'd1;
              state_nxt  = ST_IDLE;
            end
          end else begin
            // bad follow byte: invalid code point, then the byte afresh
            head_nxt    = tksd_pkg::mk_ev(tksd_pkg::EV_CHAR, inv_cp_r, 1'b0);
            rep_n_nxt   = '0;
            u8_rem_nxt  = 2'd0;
            u8_acc_nxt  = 21'd0;
            u8_lead_nxt = 8'd0;
            state_nxt   = ST_HEAD;
          end
        end else begin
          state_nxt = ST_TAIL;
        end
      end

      ST_HEAD: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_ev_nxt    = head_r;
          out_last_nxt  = (rep_n_r == '0) && !tail_ev_r;
          rep_idx_nxt   = '0;
          state_nxt     = (rep_n_r != '0) ? ST_REPLAY : ST_TAIL;
        end
      end

      ST_REPLAY: begin
        // prefix bytes are plain ASCII and leave the decoder state alone
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_ev_nxt    = dec.ev;
          out_last_nxt  = (CW'(rep_idx_r) == rep_n_r - CW'(1)) && !tail_ev_r;
          if (CW'(rep_idx_r) == rep_n_r - CW'(1)) begin
            state_nxt = ST_TAIL;
          end else begin
            rep_idx_nxt = rep_idx_r + IW'(1);
          end
        end
      end

      ST_TAIL: begin
        if (eos_r) begin
          if (out_free) begin
            out_valid_nxt = 1'b1;
            out_ev_nxt    = tksd_pkg::mk_ev(tksd_pkg::EV_EOF, 21'd0, 1'b0);
            out_last_nxt  = 1'b1;
            state_nxt     = ST_IDLE;
          end
        end else if (dec.has_ev) begin
          if (out_free) begin
            out_valid_nxt = 1'b1;
            out_ev_nxt    = dec.ev;
            out_last_nxt  = 1'b1;
            state_nxt     = ST_IDLE;
          end
        end else begin
          // no event: start an escape or a multi-byte character
          if (dec.start_esc) begin
            esc_active_nxt = 1'b1;
            esc_count_nxt  = '0;
          end
          if (dec.start_u8) begin
            u8_rem_nxt  = dec.u8_rem;
            u8_acc_nxt  = dec.u8_acc;
            u8_lead_nxt = byte_r;
          end
          state_nxt = ST_IDLE;
        end
      end

      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      esc_active_r <= 1'b0;
      esc_count_r  <= '0;
      u8_rem_r     <= 2'd0;
      u8_acc_r     <= 21'd0;
      u8_lead_r    <= 8'd0;
      out_valid_r  <= 1'b0;
      esc_cmd_r    <= 1'b0;
      inv_cp_r     <= tksd_pkg::INVALID_CP_RESET;
    end else begin
      state_r      <= state_nxt;
      esc_active_r <= esc_active_nxt;
      esc_count_r  <= esc_count_nxt;
      u8_rem_r     <= u8_rem_nxt;
      u8_acc_r     <= u8_acc_nxt;
      u8_lead_r    <= u8_lead_nxt;
      out_valid_r  <= out_valid_nxt;
      if (buf_we) begin
        esc_bytes_r[esc_count_r[IW-1:0]] <= byte_r;
      end
      if (cfg_wr_en) begin
        case (cfg_index)
          tksd_pkg::REG_ESC_IS_COMMAND:    esc_cmd_r <= cfg_wdata[0];
          tksd_pkg::REG_INVALID_CODEPOINT: inv_cp_r  <= cfg_wdata;
          default: ;
        endcase
      end
    end
    // payload holds no reset
    byte_r     <= byte_nxt;
    eos_r      <= eos_nxt;
    head_r     <= head_nxt;
    rep_n_r    <= rep_n_nxt;
    rep_idx_r  <= rep_idx_nxt;
    tail_ev_r  <= tail_ev_nxt;
    out_ev_r   <= out_ev_nxt;
    out_last_r <= out_last_nxt;
  end

  // An escape and a multi-byte character are never open together
  a_esc_u8_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    !(esc_active_r && u8_rem_r != 2'd0))
    else $error("escape and UTF-8 character both in progress");

  // The prefix buffer never overflows
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    esc_count_r < CW'(MAX_SEQUENCE_BYTES))
    else $error("escape prefix count out of range");

  // An idle escape matcher holds no prefix
  a_count_idle: assert property (@(posedge clk) disable iff (!rst_n)
    !esc_active_r |-> esc_count_r == '0)
    else $error("prefix count left behind without an escape");

  // Replay only walks stored prefix entries
  a_replay_index: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_REPLAY |-> CW'(rep_idx_r) < rep_n_r)
    else $error("replay index beyond stored prefix");

endmodule
